/* design/rpfa_pkg.sv */
// Shared types, constants and codes for the reference-counted page frame allocator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rpfa_pkg;

  // Frame store geometry.
  localparam int NUM_FRAMES = 512;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_SHIFT = 12;

  // Transaction field widths.
  localparam int ACTION_W = 3;
  localparam int OWNER_W  = 5;
  localparam int ADDR_W   = 24;
  localparam int FIDX_W   = 9;
  localparam int STATUS_W = 2;
  localparam int REFS_W   = 7;

  localparam logic [REFS_W-1:0]  REFS_MAX   = {REFS_W{1'b1}};
  localparam logic [OWNER_W-1:0] OWNER_FREE = '0;

  // Operation codes carried on the action field.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_ASSIGN  = 3'd1,
    ACT_ADDREF  = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_PURGE   = 3'd4
  } act_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BAD     = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } fsm_e;

  // One entry of the frame store.
  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [REFS_W-1:0]  refs;
  } entry_t;

  // Request to the shared update unit.
  typedef struct packed {
    act_e               op;
    logic [OWNER_W-1:0] owner;
    logic [OWNER_W-1:0] succ;
  } alu_req_t;

  // Response of the shared update unit.
  typedef struct packed {
    logic   hit;
    logic   we;
    entry_t entry;
  } alu_rsp_t;

  // One result transaction.
  typedef struct packed {
    status_e             status;
    logic [FIDX_W-1:0]   frame;
    logic [REFS_W-1:0]   count;
  } res_t;

endpackage

/* design/refcounted_page_frame_allocator_unit.sv */
// Top level of the reference-counted page frame allocator.
// Instantiates rpfa_ctrl, rpfa_alu and rpfa_frame_ram; depends on rpfa_pkg.
`timescale 1ns / 1ps

// Keeps an owner code and a reference count for each of 512 page frames in a
// single-port store, and serves one request transaction at a time: allocate
// the lowest free frame, assign a frame by address, add a reference, release
// a reference, or purge all frames of one owner. After reset the block runs a
// clearing pass over the store and holds in_stall_o high until it is done.
// Assign, add reference and release read one frame and then update it, while
// requests rejected on their fields alone skip the store. Allocate examines
// frames in turn from frame zero (store read, then update) until it finds a
// free one or has scanned all. Purge scans every frame, except that a purge of
// owner zero has nothing to find and, like an unused action code, skips the
// store. The single store port and the shared update unit make each scan take
// its frames one at a time. The result sits in an output register, so a new
// request is taken while the last result is still stalled.

module refcounted_page_frame_allocator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rpfa_pkg::ACTION_W-1:0]      action_i,
  input  logic signed [rpfa_pkg::OWNER_W-1:0] owner_id_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]        phys_address_i,
  input  logic [rpfa_pkg::FIDX_W-1:0]        frame_index_i,
  input  logic signed [rpfa_pkg::OWNER_W-1:0] successor_owner_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rpfa_pkg::STATUS_W-1:0]      status_o,
  output logic [rpfa_pkg::FIDX_W-1:0]        frame_out_o,
  output logic [rpfa_pkg::REFS_W-1:0]        count_after_o
);
  import rpfa_pkg::*;

  logic               ram_we;
  logic [FRAME_W-1:0] ram_addr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  logic               out_valid_q;
  res_t               out_q;

  rpfa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .owner_i        (owner_id_i),
    .phys_address_i (phys_address_i),
    .frame_index_i  (frame_index_i),
    .succ_i         (successor_owner_i),
    .ram_we_o       (ram_we),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .alu_req_o      (alu_req),
    .alu_rsp_i      (alu_rsp),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  rpfa_alu u_alu (
    .req_i   (alu_req),
    .entry_i (ram_rdata),
    .rsp_o   (alu_rsp)
  );

  rpfa_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // The output register takes a result when empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign frame_out_o   = out_q.frame;
  assign count_after_o = out_q.count;

endmodule

/* design/rpfa_frame_ram.sv */
// Single-port frame store holding owner code and reference count per frame.
// Registered read, one write per cycle. Depends on rpfa_pkg.
`timescale 1ns / 1ps

module rpfa_frame_ram (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [rpfa_pkg::FRAME_W-1:0] addr_i,
  input  rpfa_pkg::entry_t      wdata_i,
  output rpfa_pkg::entry_t      rdata_o
);
  import rpfa_pkg::*;

  entry_t mem [NUM_FRAMES];
  entry_t rdata_q;

  // Write and registered read share the one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rpfa_alu.sv */
// Shared update unit: tests one frame entry and computes its new contents.
// Every operation passes each examined frame through here. Depends on rpfa_pkg.
`timescale 1ns / 1ps

module rpfa_alu (
  input  rpfa_pkg::alu_req_t req_i,
  input  rpfa_pkg::entry_t   entry_i,
  output rpfa_pkg::alu_rsp_t rsp_o
);
  import rpfa_pkg::*;

  logic              free;
  logic [REFS_W-1:0] refs_dec;

  assign free     = (entry_i.refs == '0);
  assign refs_dec = entry_i.refs - REFS_W'(1);

  // Compute the hit flag, write enable and updated entry per operation.
  always_comb begin
    rsp_o.hit   = 1'b1;
    rsp_o.we    = 1'b0;
    rsp_o.entry = entry_i;
    unique case (req_i.op)
      ACT_ALLOC, ACT_ASSIGN: begin
        rsp_o.hit         = free;
        rsp_o.we          = free;
        rsp_o.entry.owner = req_i.owner;
        rsp_o.entry.refs  = REFS_W'(1);
      end
      ACT_ADDREF: begin
        rsp_o.we = 1'b1;
        if (entry_i.refs != REFS_MAX) begin
          rsp_o.entry.refs = entry_i.refs + REFS_W'(1);
        end
      end
      ACT_RELEASE: begin
        rsp_o.we = 1'b1;
        if (free || refs_dec == '0) begin
          // The frame is (or becomes) free and loses its owner.
          rsp_o.entry.owner = OWNER_FREE;
          rsp_o.entry.refs  = '0;
        end else begin
          rsp_o.entry.refs = refs_dec;
          if (entry_i.owner == req_i.owner) begin
            rsp_o.entry.owner = req_i.succ;
          end
        end
      end
      ACT_PURGE: begin
        rsp_o.hit         = (entry_i.owner == req_i.owner);
        rsp_o.we          = rsp_o.hit;
        rsp_o.entry.owner = OWNER_FREE;
        rsp_o.entry.refs  = '0;
      end
      default: begin
        rsp_o.hit = 1'b0;
      end
    endcase
  end

endmodule

/* design/rpfa_ctrl.sv */
// Sequencer of the allocator: clearing pass, request decode, frame scans.
// Drives the frame store and the shared update unit. Depends on rpfa_pkg.
`timescale 1ns / 1ps

module rpfa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rpfa_pkg::ACTION_W-1:0] action_i,
  input  logic [rpfa_pkg::OWNER_W-1:0]  owner_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]   phys_address_i,
  input  logic [rpfa_pkg::FIDX_W-1:0]   frame_index_i,
  input  logic [rpfa_pkg::OWNER_W-1:0]  succ_i,
  // Frame store.
  output logic                          ram_we_o,
  output logic [rpfa_pkg::FRAME_W-1:0]  ram_addr_o,
  output rpfa_pkg::entry_t              ram_wdata_o,
  // Shared update unit.
  output rpfa_pkg::alu_req_t            alu_req_o,
  input  rpfa_pkg::alu_rsp_t            alu_rsp_i,
  // Result hand-off.
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output rpfa_pkg::res_t                res_o
);
  import rpfa_pkg::*;

  fsm_e                state_q, state_d;
  logic [FRAME_W-1:0]  addr_q;
  act_e                act_q;
  logic [OWNER_W-1:0]  owner_q;
  logic [OWNER_W-1:0]  succ_q;
  res_t                res_q;

  logic                accept;
  logic                last;
  logic                early_done;
  logic [FRAME_W-1:0]  start_addr;
  res_t                early_res;
  res_t                eval_res;
  act_e                act_in;

  assign accept = in_valid_i && !in_stall_o;
  assign last   = (addr_q == FRAME_W'(NUM_FRAMES - 1));
  assign act_in = act_e'(action_i);

  // Decode a new request: starting frame, and a result that needs no lookup.
  always_comb begin
    early_done = 1'b0;
    start_addr = '0;
    early_res  = '{status: STAT_OK, frame: '0, count: '0};
    unique case (act_in)
      ACT_ALLOC: begin
        start_addr = '0;
      end
      ACT_ASSIGN: begin
        start_addr = FRAME_W'(phys_address_i[ADDR_W-1:PAGE_SHIFT]);
        if (phys_address_i[PAGE_SHIFT-1:0] != '0 ||
            32'(phys_address_i[ADDR_W-1:PAGE_SHIFT]) >= NUM_FRAMES) begin
          early_done       = 1'b1;
          early_res.status = STAT_BAD;
        end
      end
      ACT_ADDREF, ACT_RELEASE: begin
        start_addr = FRAME_W'(frame_index_i);
        if (32'(frame_index_i) >= NUM_FRAMES) begin
          early_done       = 1'b1;
          early_res.status = STAT_BAD;
        end
      end
      ACT_PURGE: begin
        start_addr = '0;
        early_done = (owner_i == OWNER_FREE);
      end
      default: begin
        early_done = 1'b1;
      end
    endcase
  end

  // Result of the entry under evaluation.
  always_comb begin
    eval_res = '{status: STAT_OK, frame: FIDX_W'(addr_q), count: alu_rsp_i.entry.refs};
    unique case (act_q)
      ACT_ALLOC: begin
        if (!alu_rsp_i.hit) begin
          eval_res = '{status: STAT_NO_FREE, frame: '0, count: '0};
        end
      end
      ACT_ASSIGN: begin
        if (!alu_rsp_i.hit) begin
          eval_res = '{status: STAT_BAD, frame: '0, count: '0};
        end
      end
      ACT_ADDREF, ACT_RELEASE: begin
        eval_res = '{status: STAT_OK, frame: FIDX_W'(addr_q),
                     count: alu_rsp_i.entry.refs};
      end
      default: begin
        eval_res = '{status: STAT_OK, frame: '0, count: '0};
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = early_done ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (act_q)
          ACT_ALLOC: state_d = (alu_rsp_i.hit || last) ? S_DONE : S_READ;
          ACT_PURGE: state_d = last ? S_DONE : S_READ;
          default:   state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output logic: store port, update unit request and handshakes.
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    res_valid_o = (state_q == S_DONE);
    ram_addr_o  = addr_q;
    ram_we_o    = 1'b0;
    ram_wdata_o = alu_rsp_i.entry;
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
      end
      S_EVAL: begin
        ram_we_o = alu_rsp_i.we;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  assign alu_req_o = '{op: act_q, owner: owner_q, succ: succ_q};
  assign res_o     = res_q;

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + FRAME_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            addr_q <= start_addr;
          end
        end
        S_EVAL: begin
          if (state_d == S_READ) begin
            addr_q <= addr_q + FRAME_W'(1);
          end
        end
        default: begin
          addr_q <= addr_q;
        end
      endcase
    end
  end

  // Request and result registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) begin
      act_q   <= act_in;
      owner_q <= owner_i;
      succ_q  <= succ_i;
      res_q   <= early_res;
    end else if (state_q == S_EVAL) begin
      res_q <= eval_res;
    end
  end

endmodule
